@@ rtl/sgfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgfr_pkg
// Shared constants, types and the 5x7 font for the glyph framebuffer renderer.
// ----------------------------------------------------------------------------
package sgfr_pkg;

	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 64;
	localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
	localparam int STORE_BYTES  = PAGE_COUNT * PANEL_WIDTH;
	localparam int ADDR_W       = $clog2(STORE_BYTES);
	// widest coordinate held: 255 + 7*255, the row origin after the last glyph row
	localparam int PIX_W        = 11;
	localparam int GLYPH_ROWS   = 7;
	localparam int GLYPH_COLS   = 5;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_BEGIN = 2'd1;
	localparam logic [1:0] OP_DRAW  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_PIXEL = 2'd1;
	localparam logic [1:0] MEM_ZERO  = 2'd2;
	localparam logic [1:0] MEM_READ  = 2'd3;

	typedef struct packed {
		logic [1:0]        code;
		logic [ADDR_W-1:0] addr;
		logic [2:0]        bitpos;
		logic              lit;
	} mem_cmd_t;

	// element 0 is the top glyph row, bit 4 the leftmost column
	typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

	function automatic glyph_t font_lookup(input logic [7:0] code);
		glyph_t g;
		case (code)
			8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
			8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
			8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
			8'h33: g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
			8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
			8'h35: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
			8'h36: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
			8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
			8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
			8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
			8'h3A: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
			8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
			8'h43: g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
			8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
			8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
			8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
			8'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
			8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
			8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
			8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h15, 5'h13, 5'h11, 5'h11};
			8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
			8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
			8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
			8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
			8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
			8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
			8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
			8'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
			8'h6D: g = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h15, 5'h15};
			8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
			// space and every unknown code
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

@@ rtl/sgfr_pixel_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sgfr_pixel_unit
// Framebuffer memory with a pipelined single-bit read-modify-write path.
// ----------------------------------------------------------------------------
module sgfr_pixel_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sgfr_pkg::mem_cmd_t cmd,
	output logic [7:0]             rdata
);

	logic [7:0] mem_q [sgfr_pkg::STORE_BYTES];
	logic [7:0] rdata_q;

	logic                        pend_v_s1;
	logic [sgfr_pkg::ADDR_W-1:0] pend_addr_s1;
	logic [2:0]                  pend_bit_s1;
	logic                        pend_lit_s1;

	logic                        last_v_q;
	logic [sgfr_pkg::ADDR_W-1:0] last_addr_q;
	logic [7:0]                  last_data_q;

	logic [7:0]                  old_byte;
	logic [7:0]                  mask;
	logic [7:0]                  new_byte;
	logic                        we;
	logic [sgfr_pkg::ADDR_W-1:0] wa;
	logic [7:0]                  wd;

	// the byte written on the previous edge is not yet in rdata_q
	assign old_byte = (last_v_q && last_addr_q == pend_addr_s1) ? last_data_q : rdata_q;
	assign mask     = 8'd1 << pend_bit_s1;
	assign new_byte = pend_lit_s1 ? (old_byte | mask) : (old_byte & ~mask);

	assign we = pend_v_s1 || (cmd.code == sgfr_pkg::MEM_ZERO);
	assign wa = pend_v_s1 ? pend_addr_s1 : cmd.addr;
	assign wd = pend_v_s1 ? new_byte : 8'd0;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rdata_q <= mem_q[cmd.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_s1 <= 1'b0;
			last_v_q  <= 1'b0;
		end else begin
			pend_v_s1 <= (cmd.code == sgfr_pkg::MEM_PIXEL);
			last_v_q  <= pend_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_s1 <= cmd.addr;
		pend_bit_s1  <= cmd.bitpos;
		pend_lit_s1  <= cmd.lit;
		last_addr_q  <= pend_addr_s1;
		last_data_q  <= new_byte;
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/scaled_glyph_framebuffer_renderer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_glyph_framebuffer_renderer
// Page-format monochrome framebuffer with a scaled 5x7 font text writer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | operation x_start y_start scale char_code byte_index
//  out     | output    | out_valid/out_stall| read_byte cursor_column
//
//  one request at a time; the pixel sequencer issues one framebuffer pixel a cycle
//  draw: scale*scale framebuffer pixels per glyph pixel, fewer where the glyph is clipped
//  clear: one byte a cycle over all STORE_BYTES bytes; begin: straight to the response; read: issue, wait, respond
//  after reset a clearing pass over all STORE_BYTES bytes runs before the first request
//  a result waits in the output register while out_stall is high
// ----------------------------------------------------------------------------
module scaled_glyph_framebuffer_renderer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] operation,
	input  wire logic [7:0] x_start,
	input  wire logic [7:0] y_start,
	input  wire logic [7:0] scale,
	input  wire logic [7:0] char_code,
	input  wire logic [9:0] byte_index,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_byte,
	output logic [7:0]      cursor_column
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_CLEAR    = 3'd1;
	localparam logic [2:0] ST_DRAW     = 3'd2;
	localparam logic [2:0] ST_RD_ISSUE = 3'd3;
	localparam logic [2:0] ST_RD_WAIT  = 3'd4;
	localparam logic [2:0] ST_RESP     = 3'd5;

	localparam int PW = sgfr_pkg::PIX_W;
	localparam int AW = sgfr_pkg::ADDR_W;

	logic [2:0]    state_q;
	logic          boot_q;
	logic [AW-1:0] clr_cnt_q;
	logic [7:0]    cursor_q;
	logic [7:0]    row_q;
	logic [7:0]    scale_q;
	sgfr_pkg::glyph_t glyph_q;
	logic [2:0]    r_q;
	logic [2:0]    c_q;
	logic [7:0]    sy_q;
	logic [7:0]    sx_q;
	logic [PW-1:0] xcol_q;
	logic [PW-1:0] yrow_q;
	logic [PW-1:0] px_q;
	logic [PW-1:0] py_q;
	logic [9:0]    idx_q;
	logic [7:0]    read_byte_q;

	sgfr_pkg::mem_cmd_t cmd;
	logic [7:0]    mem_rdata;
	logic          in_fire;
	logic          pix_in_range;
	logic          sx_last;
	logic          sy_last;
	logic [PW-1:0] s_pix;
	logic [AW-1:0] pix_addr;
	logic          idx_ok;

	assign in_fire   = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_RESP);
	assign read_byte = read_byte_q;
	assign cursor_column = cursor_q;

	assign s_pix        = PW'(scale_q);
	assign pix_in_range = (px_q < PW'(sgfr_pkg::PANEL_WIDTH)) &&
	                      (py_q < PW'(sgfr_pkg::PANEL_HEIGHT));
	assign sx_last      = (sx_q == scale_q - 8'd1) ||
	                      (px_q >= PW'(sgfr_pkg::PANEL_WIDTH - 1));
	assign sy_last      = (sy_q == scale_q - 8'd1) ||
	                      (py_q >= PW'(sgfr_pkg::PANEL_HEIGHT - 1));
	assign pix_addr     = AW'((32'(py_q) >> 3) * sgfr_pkg::PANEL_WIDTH + 32'(px_q));
	assign idx_ok       = (32'(idx_q) < sgfr_pkg::STORE_BYTES);

	always_comb begin
		cmd        = '0;
		cmd.code   = sgfr_pkg::MEM_NONE;
		case (state_q)
			ST_CLEAR: begin
				cmd.code = sgfr_pkg::MEM_ZERO;
				cmd.addr = clr_cnt_q;
			end
			ST_DRAW: begin
				cmd.code   = pix_in_range ? sgfr_pkg::MEM_PIXEL : sgfr_pkg::MEM_NONE;
				cmd.addr   = pix_addr;
				cmd.bitpos = py_q[2:0];
				cmd.lit    = glyph_q[r_q][3'd4 - c_q];
			end
			ST_RD_ISSUE: begin
				cmd.code = sgfr_pkg::MEM_READ;
				cmd.addr = AW'(idx_q);
			end
			default: begin
				cmd.code = sgfr_pkg::MEM_NONE;
			end
		endcase
	end

	sgfr_pixel_unit u_pixel (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rdata  (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			boot_q    <= 1'b1;
			clr_cnt_q <= '0;
			cursor_q  <= 8'd0;
			row_q     <= 8'd0;
			scale_q   <= 8'd1;
			r_q       <= '0;
			c_q       <= '0;
			sy_q      <= '0;
			sx_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (operation)
							sgfr_pkg::OP_CLEAR: begin
								clr_cnt_q <= '0;
								boot_q    <= 1'b0;
								state_q   <= ST_CLEAR;
							end
							sgfr_pkg::OP_BEGIN: begin
								cursor_q <= x_start;
								row_q    <= y_start;
								scale_q  <= (scale == 8'd0) ? 8'd1 : scale;
								state_q  <= ST_RESP;
							end
							sgfr_pkg::OP_DRAW: begin
								r_q     <= '0;
								c_q     <= '0;
								sy_q    <= '0;
								sx_q    <= '0;
								state_q <= ST_DRAW;
							end
							default: begin
								state_q <= ST_RD_ISSUE;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(sgfr_pkg::STORE_BYTES - 1)) begin
						state_q <= boot_q ? ST_IDLE : ST_RESP;
					end
				end
				ST_DRAW: begin
					// sx innermost, then sy, then glyph column, then glyph row
					if (!sx_last) begin
						sx_q <= sx_q + 8'd1;
					end else if (!sy_last) begin
						sx_q <= '0;
						sy_q <= sy_q + 8'd1;
					end else if (c_q != 3'(sgfr_pkg::GLYPH_COLS - 1)) begin
						sx_q <= '0;
						sy_q <= '0;
						c_q  <= c_q + 3'd1;
					end else if (r_q != 3'(sgfr_pkg::GLYPH_ROWS - 1)) begin
						sx_q <= '0;
						sy_q <= '0;
						c_q  <= '0;
						r_q  <= r_q + 3'd1;
					end else begin
						cursor_q <= cursor_q + {scale_q[5:0], 2'b00} + {scale_q[6:0], 1'b0};
						state_q  <= ST_RESP;
					end
				end
				ST_RD_ISSUE: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// coordinate and payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				glyph_q     <= sgfr_pkg::font_lookup(char_code);
				idx_q       <= byte_index;
				read_byte_q <= 8'd0;
				xcol_q      <= PW'(cursor_q);
				px_q        <= PW'(cursor_q);
				yrow_q      <= PW'(row_q);
				py_q        <= PW'(row_q);
			end
			ST_DRAW: begin
				if (!sx_last) begin
					px_q <= px_q + PW'(1);
				end else if (!sy_last) begin
					px_q <= xcol_q;
					py_q <= py_q + PW'(1);
				end else if (c_q != 3'(sgfr_pkg::GLYPH_COLS - 1)) begin
					xcol_q <= xcol_q + s_pix;
					px_q   <= xcol_q + s_pix;
					py_q   <= yrow_q;
				end else begin
					xcol_q <= PW'(cursor_q);
					px_q   <= PW'(cursor_q);
					yrow_q <= yrow_q + s_pix;
					py_q   <= yrow_q + s_pix;
				end
			end
			ST_RD_WAIT: begin
				read_byte_q <= idx_ok ? mem_rdata : 8'd0;
			end
			default: begin
				read_byte_q <= read_byte_q;
			end
		endcase
	end

	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while a result is pending");

	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		scale_q != 8'd0)
		else $error("stored scale is zero");

	a_glyph_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) |-> (r_q < 3'd7 && c_q < 3'd5))
		else $error("glyph counters out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> in_stall)
		else $error("sequencer not busy after a request");

endmodule
`default_nettype wire
